@@ sv/all_pairs_shortest_path_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the all-pairs shortest path block
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication.
`define APSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apsp assertion failed");

// Next-cycle implication.
`define APSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apsp assertion failed");

`endif

@@ sv/apsp_pkg.sv @@
// ---------------------------------------------------------------------------
// apsp_pkg
// Types, constants and cost arithmetic shared by the shortest path block.
// ---------------------------------------------------------------------------
package apsp_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam int VERTEX_BITS  = 4;
  localparam int COST_BITS    = 20;
  localparam int DIST_BITS    = COST_BITS + 1;
  localparam int VCOUNT_BITS  = 5;
  localparam int VCOUNT_RESET = 16;
  localparam int PATH_DEPTH   = 16;
  localparam int PATH_AW      = $clog2(PATH_DEPTH);
  localparam int PATH_CW      = $clog2(PATH_DEPTH + 1);

  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] COST_INF = {1'b1, {COST_BITS{1'b0}}};

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV_LD,
    ST_RMW,
    ST_Q_CHK,
    ST_Q_WALK,
    ST_SINGLE,
    ST_POP_RD,
    ST_POP_EM
  } state_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex;
    logic [COST_BITS-1:0]   cost;
    logic                   unreachable;
    logic                   path_empty;
    logic                   last;
  } res_t;

  // Saturating add where the top bit marks infinity, which is sticky.
  function automatic logic [DIST_BITS-1:0] cost_add(input logic [DIST_BITS-1:0] a,
                                                    input logic [DIST_BITS-1:0] b);
    logic [DIST_BITS-1:0] s;
    s = {1'b0, a[COST_BITS-1:0]} + {1'b0, b[COST_BITS-1:0]};
    if (a[COST_BITS] || b[COST_BITS]) begin
      return COST_INF;
    end
    if (s[COST_BITS]) begin
      return {1'b0, COST_MAX};
    end
    return s;
  endfunction

endpackage

@@ sv/all_pairs_shortest_path.sv @@
// ---------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall all-pairs shortest path engine with path readout.
// ---------------------------------------------------------------------------
// A load is written to the tables as it is accepted. A solve visits each row
// of each pivot in turn: it fetches the pivot cost, starts the row read, then
// does one read-modify-write of the distance and predecessor RAMs per entry.
// A query is accepted, then looks up the pair and stacks the destination,
// walks the predecessor RAM once per further path vertex, then reads each
// stacked vertex and emits it (or emits a single result); the input is not
// ready until the query's last result is in the output register. Tables hold
// no reset value, so no clearing pass runs: load every entry of the n-by-n
// matrix before solving or querying.
module all_pairs_shortest_path #(
  parameter int MAX_VERTICES = apsp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = apsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [apsp_pkg::VCOUNT_BITS-1:0]        cfg_wr_data,   // vertex_count
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // row_vertex, col_vertex, edge_weight, edge_absent, zero fill
  input  logic [((9 + WEIGHT_BITS + 7) / 8) * 8-1:0] in_tdata,
  input  logic [1:0]                              in_tuser,      // cmd
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [23:0]                             out_tdata,     // path_vertex, path_cost
  output logic [1:0]                              out_tuser,     // unreachable, path_empty
  output logic                                    out_tlast
);

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int VB = apsp_pkg::VERTEX_BITS;

  logic [apsp_pkg::VCOUNT_BITS-1:0] vcount_r;
  logic [NW-1:0]  n;
  logic           out_free, res_valid;
  apsp_pkg::res_t res, out_res_r;
  logic           out_valid_r;

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= apsp_pkg::VCOUNT_BITS'(apsp_pkg::VCOUNT_RESET);
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data;
    end
  end

  // Clamp the count into 1..MAX_VERTICES.
  always_comb begin
    if (vcount_r == '0) begin
      n = NW'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(vcount_r);
    end
  end

  apsp_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .NW          (NW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .n        (n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_row   (in_tdata[VB-1:0]),
    .in_col   (in_tdata[2*VB-1:VB]),
    .in_weight(in_tdata[2*VB +: WEIGHT_BITS]),
    .in_absent(in_tdata[2*VB + WEIGHT_BITS]),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register decouples the sequencer from the result consumer.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.cost, out_res_r.vertex};
  assign out_tuser  = {out_res_r.path_empty, out_res_r.unreachable};
  assign out_tlast  = out_res_r.last;

endmodule

@@ sv/apsp_ram.sv @@
// ---------------------------------------------------------------------------
// apsp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module apsp_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/apsp_ctrl.sv @@
// ---------------------------------------------------------------------------
// apsp_ctrl
// Sequencer for load, Floyd-Warshall solve and path readout over the tables.
// ---------------------------------------------------------------------------
module apsp_ctrl #(
  parameter int MAX_VERTICES = apsp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = apsp_pkg::DEF_WEIGHT_BITS,
  parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [NW-1:0]                       n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [apsp_pkg::VERTEX_BITS-1:0]    in_row,
  input  logic [apsp_pkg::VERTEX_BITS-1:0]    in_col,
  input  logic [WEIGHT_BITS-1:0]              in_weight,
  input  logic                                in_absent,
  input  logic                                out_free,
  output logic                                res_valid,
  output apsp_pkg::res_t                      res
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VW;
  localparam int PW = VW + 1;
  localparam int DW = apsp_pkg::DIST_BITS;
  localparam int CB = apsp_pkg::COST_BITS;
  localparam int WX = (WEIGHT_BITS > CB) ? WEIGHT_BITS : CB;
  localparam logic [apsp_pkg::PATH_CW-1:0] STK_FULL = apsp_pkg::PATH_CW'(apsp_pkg::PATH_DEPTH);

  apsp_pkg::state_t state_r, state_nxt;
  logic [VW-1:0] k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [VW-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic [DW-1:0] dik_r, dik_nxt, d_r, d_nxt;
  logic          oor_r, oor_nxt;
  logic [apsp_pkg::PATH_CW-1:0] cnt_r, cnt_nxt;
  logic [apsp_pkg::PATH_AW-1:0] idx_r, idx_nxt;
  apsp_pkg::res_t sres_r, sres_nxt;

  // Memory ports.
  logic          dist_we, pred_we, stk_we;
  logic [AW-1:0] dist_waddr, pred_waddr, raddr_a, raddr_b, raddr_p;
  logic [DW-1:0] dist_wdata, rd_a, rd_b;
  logic [PW-1:0] pred_wdata, rd_p;
  logic [apsp_pkg::PATH_AW-1:0] stk_waddr, stk_raddr;
  logic [VW-1:0] stk_wdata, stk_rd;

  logic [WX-1:0]  wx;
  logic [CB-1:0]  load_cost;
  logic [DW-1:0]  sum;
  logic           upd;
  logic [VW-1:0]  p_v;
  logic           j_last, i_last, k_last;

  // Two copies of the distance table give two reads per cycle.
  apsp_ram #(.DATA_W(DW), .ADDR_W(AW)) u_dist_a (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(raddr_a), .rdata(rd_a)
  );
  apsp_ram #(.DATA_W(DW), .ADDR_W(AW)) u_dist_b (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(raddr_b), .rdata(rd_b)
  );
  apsp_ram #(.DATA_W(PW), .ADDR_W(AW)) u_pred (
    .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
    .raddr(raddr_p), .rdata(rd_p)
  );
  apsp_ram #(.DATA_W(VW), .ADDR_W(apsp_pkg::PATH_AW)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  // Load value with saturation of wide weights.
  assign wx        = WX'(in_weight);
  assign load_cost = (wx > WX'(apsp_pkg::COST_MAX)) ? apsp_pkg::COST_MAX : CB'(wx);

  // Relaxation: pivot cost held in dik_r, row of k on port A, entry on B.
  assign sum = apsp_pkg::cost_add(dik_r, rd_a);
  assign upd = rd_b > sum;

  assign j_last = (NW'(j_r) + NW'(1)) == n;
  assign i_last = (NW'(i_r) + NW'(1)) == n;
  assign k_last = (NW'(k_r) + NW'(1)) == n;
  assign p_v    = rd_p[VW-1:0];

  // State and loop registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apsp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    dik_r  <= dik_nxt;
    d_r    <= d_nxt;
    oor_r  <= oor_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    sres_r <= sres_nxt;
  end

  // Next state, memory addressing and result generation.
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    dik_nxt    = dik_r;
    d_nxt      = d_r;
    oor_nxt    = oor_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    sres_nxt   = sres_r;
    in_ready   = 1'b0;
    dist_we    = 1'b0;
    pred_we    = 1'b0;
    stk_we     = 1'b0;
    dist_waddr = {i_r, j_r};
    pred_waddr = {i_r, j_r};
    dist_wdata = sum;
    pred_wdata = rd_p;
    raddr_a    = {k_r, j_r + VW'(1)};
    raddr_b    = {i_r, j_r + VW'(1)};
    raddr_p    = {k_r, j_r + VW'(1)};
    stk_waddr  = apsp_pkg::PATH_AW'(cnt_r);
    stk_wdata  = p_v;
    stk_raddr  = idx_r;
    res_valid  = 1'b0;
    res        = sres_r;

    case (state_r)
      apsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        raddr_b  = {VW'(in_row), VW'(in_col)};
        if (in_valid) begin
          case (in_cmd)
            apsp_pkg::CMD_LOAD: begin
              if (32'(in_row) < MAX_VERTICES && 32'(in_col) < MAX_VERTICES) begin
                dist_we    = 1'b1;
                pred_we    = 1'b1;
                dist_waddr = {VW'(in_row), VW'(in_col)};
                pred_waddr = {VW'(in_row), VW'(in_col)};
                dist_wdata = in_absent ? apsp_pkg::COST_INF : {1'b0, load_cost};
                pred_wdata = in_absent ? {1'b1, VW'(0)} : {1'b0, VW'(in_row)};
              end
            end
            apsp_pkg::CMD_SOLVE: begin
              k_nxt     = '0;
              i_nxt     = '0;
              state_nxt = apsp_pkg::ST_PIV_RD;
            end
            apsp_pkg::CMD_QUERY: begin
              src_nxt   = VW'(in_row);
              dst_nxt   = VW'(in_col);
              oor_nxt   = (32'(in_row) >= 32'(n)) || (32'(in_col) >= 32'(n));
              state_nxt = apsp_pkg::ST_Q_CHK;
            end
            default: begin
            end
          endcase
        end
      end

      // Fetch cost(i,k) for the coming row.
      apsp_pkg::ST_PIV_RD: begin
        raddr_a   = {i_r, k_r};
        state_nxt = apsp_pkg::ST_PIV_LD;
      end

      // Hold the pivot cost and start reading row entries at j = 0.
      apsp_pkg::ST_PIV_LD: begin
        dik_nxt   = rd_a;
        raddr_a   = {k_r, VW'(0)};
        raddr_b   = {i_r, VW'(0)};
        raddr_p   = {k_r, VW'(0)};
        j_nxt     = '0;
        state_nxt = apsp_pkg::ST_RMW;
      end

      // One entry per cycle: compare, write back, read the next one.
      // Row k and column k never change in phase k, so no forwarding is needed.
      apsp_pkg::ST_RMW: begin
        dist_we = upd;
        pred_we = upd;
        j_nxt   = j_r + VW'(1);
        if (j_last) begin
          if (i_last) begin
            i_nxt = '0;
            k_nxt = k_r + VW'(1);
            state_nxt = k_last ? apsp_pkg::ST_IDLE : apsp_pkg::ST_PIV_RD;
          end else begin
            i_nxt     = i_r + VW'(1);
            state_nxt = apsp_pkg::ST_PIV_RD;
          end
        end
      end

      // Pair cost is back; decide between a single result and a walk.
      apsp_pkg::ST_Q_CHK: begin
        d_nxt     = rd_b;
        raddr_p   = {src_r, dst_r};
        sres_nxt  = '{vertex: '0, cost: '0, unreachable: 1'b1,
                      path_empty: 1'b1, last: 1'b1};
        if (oor_r || rd_b[CB]) begin
          state_nxt = apsp_pkg::ST_SINGLE;
        end else if (src_r == dst_r) begin
          sres_nxt.cost        = rd_b[CB-1:0];
          sres_nxt.unreachable = 1'b0;
          state_nxt            = apsp_pkg::ST_SINGLE;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = dst_r;
          cnt_nxt   = apsp_pkg::PATH_CW'(1);
          state_nxt = apsp_pkg::ST_Q_WALK;
        end
      end

      // Follow predecessors back toward the source, one per cycle.
      apsp_pkg::ST_Q_WALK: begin
        raddr_p = {src_r, p_v};
        if (rd_p[VW] || NW'(p_v) >= n ||
            cnt_r >= apsp_pkg::PATH_CW'(apsp_pkg::PATH_DEPTH)) begin
          sres_nxt  = '{vertex: '0, cost: d_r[CB-1:0], unreachable: 1'b0,
                        path_empty: 1'b1, last: 1'b1};
          state_nxt = apsp_pkg::ST_SINGLE;
        end else begin
          stk_we  = 1'b1;
          cnt_nxt = cnt_r + apsp_pkg::PATH_CW'(1);
          if (p_v == src_r) begin
            idx_nxt   = apsp_pkg::PATH_AW'(cnt_r);
            state_nxt = apsp_pkg::ST_POP_RD;
          end
        end
      end

      apsp_pkg::ST_SINGLE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = apsp_pkg::ST_IDLE;
        end
      end

      apsp_pkg::ST_POP_RD: begin
        state_nxt = apsp_pkg::ST_POP_EM;
      end

      // Stack top is the source, so popping yields source-first order.
      apsp_pkg::ST_POP_EM: begin
        res = '{vertex: apsp_pkg::VERTEX_BITS'(stk_rd), cost: d_r[CB-1:0],
                unreachable: 1'b0, path_empty: 1'b0, last: (idx_r == '0)};
        if (out_free) begin
          res_valid = 1'b1;
          idx_nxt   = idx_r - apsp_pkg::PATH_AW'(1);
          state_nxt = (idx_r == '0) ? apsp_pkg::ST_IDLE : apsp_pkg::ST_POP_RD;
        end
      end

      default: begin
        state_nxt = apsp_pkg::ST_IDLE;
      end
    endcase
  end

`include "all_pairs_shortest_path_assert.svh"

  // A result is only offered when the output stage can take it.
  `APSP_ASSERT_IMPL(a_res_when_free, clk, rst_n, res_valid, out_free)
  // The final result of a query returns the sequencer to idle.
  `APSP_ASSERT_NEXT(a_last_to_idle, clk, rst_n, res_valid && res.last, state_r == apsp_pkg::ST_IDLE)
  // The walk never stacks more vertices than the path store holds.
  `APSP_ASSERT_IMPL(a_walk_bound, clk, rst_n, state_r == apsp_pkg::ST_Q_WALK, cnt_r <= STK_FULL)

endmodule
